/* src/calendar_date_difference_defines.svh */
// ----------------------------------------------------------------------------
// calendar_date_difference_defines
// Assertion macros used by the checker file of the date difference block.
// ----------------------------------------------------------------------------
`ifndef CALENDAR_DATE_DIFFERENCE_DEFINES_SVH
`define CALENDAR_DATE_DIFFERENCE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define CDD_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is low
`define CDD_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/cdd_pkg.sv */
// ----------------------------------------------------------------------------
// cdd_pkg
// Types, constants and the month table of the date difference block.
// ----------------------------------------------------------------------------
package cdd_pkg;

	localparam int YEAR_BITS_DEF = 14;
	localparam int SPAN_W        = 23;
	localparam int DAY_W         = 5;
	localparam int MONTH_W       = 4;

	localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MON_MAR = 4'd3;
	localparam logic [MONTH_W-1:0] MON_APR = 4'd4;
	localparam logic [MONTH_W-1:0] MON_MAY = 4'd5;
	localparam logic [MONTH_W-1:0] MON_JUN = 4'd6;
	localparam logic [MONTH_W-1:0] MON_JUL = 4'd7;
	localparam logic [MONTH_W-1:0] MON_AUG = 4'd8;
	localparam logic [MONTH_W-1:0] MON_SEP = 4'd9;
	localparam logic [MONTH_W-1:0] MON_OCT = 4'd10;
	localparam logic [MONTH_W-1:0] MON_NOV = 4'd11;
	localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;

	localparam logic [DAY_W-1:0] DAY_LONG  = 5'd31;
	localparam logic [DAY_W-1:0] DAY_SHORT = 5'd30;
	localparam logic [DAY_W-1:0] DAY_LEAP  = 5'd29;

	// per-stage load enables for the ordinal pipeline
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
	} stage_en_t;

	// days before the first of the month in a common year
	function automatic logic [8:0] month_start(input logic [MONTH_W-1:0] m);
		logic [8:0] r;
		case (m)
			MON_JAN: r = 9'd0;
			MON_FEB: r = 9'd31;
			MON_MAR: r = 9'd59;
			MON_APR: r = 9'd90;
			MON_MAY: r = 9'd120;
			MON_JUN: r = 9'd151;
			MON_JUL: r = 9'd181;
			MON_AUG: r = 9'd212;
			MON_SEP: r = 9'd243;
			MON_OCT: r = 9'd273;
			MON_NOV: r = 9'd304;
			MON_DEC: r = 9'd334;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

/* src/cdd_ordinal.sv */
// ----------------------------------------------------------------------------
// cdd_ordinal
// Three-stage pipeline: one date to its day number and a validity flag.
// ----------------------------------------------------------------------------
module cdd_ordinal
	import cdd_pkg::*;
#(
	parameter int YEAR_BITS = YEAR_BITS_DEF
) (
	input  logic                   clk,
	input  stage_en_t              en,
	input  logic [DAY_W-1:0]       day,
	input  logic [MONTH_W-1:0]     month,
	input  logic [YEAR_BITS-1:0]   year,
	output logic [YEAR_BITS+8:0]   ordinal,
	output logic                   date_ok
);

	// x/25 as (x*MUL)>>SH, exact for x below 2**(YEAR_BITS-1)
	localparam int SH    = YEAR_BITS + 5;
	localparam int MUL   = (2**SH + 24) / 25;
	localparam int T_W   = YEAR_BITS - 1;
	localparam int P_W   = 2 * YEAR_BITS;
	localparam int Q_W   = P_W - SH;
	localparam int X_W   = YEAR_BITS + 1;
	localparam int ORD_W = YEAR_BITS + 9;

	// stage 1: reciprocal products and the year-free checks
	logic [X_W-1:0] x100, x400;
	logic [T_W-1:0] t100, t400;
	logic           range_ok, feb29;

	assign x100 = {1'b0, year} + X_W'(99);
	assign x400 = {1'b0, year} + X_W'(399);
	assign t100 = x100[YEAR_BITS:2];
	assign t400 = T_W'(x400[YEAR_BITS:4]);

	always_comb begin
		range_ok = (month inside {[MON_JAN:MON_DEC]}) && (day != '0);
		if (day == DAY_LONG && (month inside {MON_APR, MON_JUN, MON_SEP, MON_NOV}))
			range_ok = 1'b0;
		if (month == MON_FEB && (day == DAY_SHORT || day == DAY_LONG))
			range_ok = 1'b0;
		feb29 = (month == MON_FEB) && (day == DAY_LEAP);
	end

	logic [P_W-1:0]       p100_s1, p400_s1;
	logic [YEAR_BITS-1:0] year_s1;
	logic [DAY_W-1:0]     day_s1;
	logic [MONTH_W-1:0]   month_s1;
	logic                 range_ok_s1, feb29_s1;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			p100_s1     <= P_W'(t100) * P_W'(MUL);
			p400_s1     <= P_W'(t400) * P_W'(MUL);
			year_s1     <= year;
			day_s1      <= day;
			month_s1    <= month;
			range_ok_s1 <= range_ok;
			feb29_s1    <= feb29;
		end
	end

	// stage 2: rounded-up quotients, leap flag, 365*y + leap days so far
	logic [Q_W-1:0] c100, c400;
	logic [X_W-1:0] x4;
	logic [T_W-1:0] c4, leaps;
	logic           leap;

	assign c100  = p100_s1[P_W-1:SH];
	assign c400  = p400_s1[P_W-1:SH];
	assign x4    = {1'b0, year_s1} + X_W'(3);
	assign c4    = x4[YEAR_BITS:2];
	assign leaps = c4 - T_W'(c100) + T_W'(c400);
	// y is a multiple of k exactly when ceil(y/k)*k == y
	assign leap  = (year_s1[1:0] == 2'b00)
		&& ((X_W'(c100) * X_W'(100) != {1'b0, year_s1})
		|| (X_W'(c400) * X_W'(400) == {1'b0, year_s1}));

	logic [ORD_W-1:0]   base_s2;
	logic [DAY_W-1:0]   day_s2;
	logic [MONTH_W-1:0] month_s2;
	logic               leap_s2, ok_s2;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			base_s2  <= ORD_W'(year_s1) * ORD_W'(365) + ORD_W'(leaps);
			day_s2   <= day_s1;
			month_s2 <= month_s1;
			leap_s2  <= leap;
			ok_s2    <= range_ok_s1 && !(feb29_s1 && !leap);
		end
	end

	// stage 3: add month offset, day and this year's leap day
	logic late_leap;
	assign late_leap = leap_s2 && (month_s2 > MON_FEB);

	logic [ORD_W-1:0] ord_s3;
	logic             ok_s3;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			ord_s3 <= base_s2 + ORD_W'(month_start(month_s2)) + ORD_W'(day_s2)
				+ ORD_W'(late_leap);
			ok_s3  <= ok_s2;
		end
	end

	assign ordinal = ord_s3;
	assign date_ok = ok_s3;

endmodule

/* src/calendar_date_difference.sv */
// ----------------------------------------------------------------------------
// calendar_date_difference
// Signed day count between two Gregorian dates, fully pipelined.
// ----------------------------------------------------------------------------
// Usage
//   Request channel (req_valid / req_stall) carries one date pair per beat:
//   first_* is the start date, last_* the end date. Years are taken as
//   YEAR_BITS unsigned bits, proleptic Gregorian, year 0 leap.
//   Response channel (rsp_valid / rsp_stall) returns one beat per request:
//   dates_ok, and day_span = end minus start in days, saturated to 23 bits
//   signed. If either date is invalid, dates_ok and day_span are both 0.
//   Four pipeline stages lie between an accepted request and rsp_valid:
//   reciprocal multiply, leap count, ordinal sum, difference and clamp.
//   One beat per cycle is sustained while the response side is not stalled.
//   Each stage holds its beat only while the stage ahead is full and held,
//   so a stall on the response side fills empty stages first and reaches
//   req_stall once all four are occupied. No beat is dropped or repeated.
//   Reset (arst_n low) empties the pipeline at once; payload is not cleared.
// ----------------------------------------------------------------------------
module calendar_date_difference
	import cdd_pkg::*;
#(
	parameter int YEAR_BITS = YEAR_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_stall,
	input  logic [DAY_W-1:0]         first_day,
	input  logic [MONTH_W-1:0]       first_month,
	input  logic [YEAR_BITS-1:0]     first_year,
	input  logic [DAY_W-1:0]         last_day,
	input  logic [MONTH_W-1:0]       last_month,
	input  logic [YEAR_BITS-1:0]     last_year,
	output logic                     rsp_valid,
	input  logic                     rsp_stall,
	output logic                     dates_ok,
	output logic signed [SPAN_W-1:0] day_span
);

	localparam int ORD_W  = YEAR_BITS + 9;
	// two spare bits: room for the sign and for clamp compares at 23 bits
	localparam int DIFF_W = ORD_W + 2;
	localparam logic signed [DIFF_W-1:0] SPAN_HI = DIFF_W'(2**(SPAN_W-1) - 1);
	localparam logic signed [DIFF_W-1:0] SPAN_LO = DIFF_W'(-(2**(SPAN_W-1)));

	// --- flow control -------------------------------------------------------
	// A stage may load when it is empty or the stage ahead loads too.
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	assign rdy4 = !valid_s4 || !rsp_stall;
	assign rdy3 = !valid_s3 || rdy4;
	assign rdy2 = !valid_s2 || rdy3;
	assign rdy1 = !valid_s1 || rdy2;

	assign req_stall = !rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= req_valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
		end
	end

	stage_en_t en;
	assign en.s1 = rdy1;
	assign en.s2 = rdy2;
	assign en.s3 = rdy3;

	// --- day numbers of both dates, stages 1 to 3 ----------------------------
	logic [ORD_W-1:0] first_ord, last_ord;
	logic             first_ok, last_ok;

	cdd_ordinal #(.YEAR_BITS(YEAR_BITS)) u_first (
		.clk     (clk),
		.en      (en),
		.day     (first_day),
		.month   (first_month),
		.year    (first_year),
		.ordinal (first_ord),
		.date_ok (first_ok)
	);

	cdd_ordinal #(.YEAR_BITS(YEAR_BITS)) u_last (
		.clk     (clk),
		.en      (en),
		.day     (last_day),
		.month   (last_month),
		.year    (last_year),
		.ordinal (last_ord),
		.date_ok (last_ok)
	);

	// --- stage 4: difference, clamp, zero on a bad date ----------------------
	logic signed [DIFF_W-1:0] diff;
	logic signed [SPAN_W-1:0] span_clamped;
	logic                     both_ok;

	assign diff    = signed'(DIFF_W'(last_ord)) - signed'(DIFF_W'(first_ord));
	assign both_ok = first_ok && last_ok;

	always_comb begin
		if (diff > SPAN_HI)
			span_clamped = SPAN_HI[SPAN_W-1:0];
		else if (diff < SPAN_LO)
			span_clamped = SPAN_LO[SPAN_W-1:0];
		else
			span_clamped = diff[SPAN_W-1:0];
	end

	logic                     dates_ok_s4;
	logic signed [SPAN_W-1:0] day_span_s4;

	always_ff @(posedge clk) begin
		if (rdy4) begin
			dates_ok_s4 <= both_ok;
			day_span_s4 <= both_ok ? span_clamped : '0;
		end
	end

	assign rsp_valid = valid_s4;
	assign dates_ok  = dates_ok_s4;
	assign day_span  = day_span_s4;

endmodule

/* src/cdd_checker.sv */
// ----------------------------------------------------------------------------
// cdd_checker
// Port-level checks on the date difference block, bound to the top level.
// ----------------------------------------------------------------------------
`include "calendar_date_difference_defines.svh"

module cdd_checker
	import cdd_pkg::*;
(
	input logic                     clk,
	input logic                     arst_n,
	input logic                     req_valid,
	input logic                     req_stall,
	input logic                     rsp_valid,
	input logic                     rsp_stall,
	input logic                     dates_ok,
	input logic signed [SPAN_W-1:0] day_span
);

	// beats inside the block; four stages at most
	logic [2:0] inflight_q;
	logic       take_req, take_rsp;

	assign take_req = req_valid && !req_stall;
	assign take_rsp = rsp_valid && !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			case ({take_req, take_rsp})
				2'b10:   inflight_q <= inflight_q + 3'd1;
				2'b01:   inflight_q <= inflight_q - 3'd1;
				default: inflight_q <= inflight_q;
			endcase
		end
	end

	`CDD_ASSERT_IMP(a_bad_date_zero, clk, arst_n, rsp_valid && !dates_ok, day_span == '0, "bad date with nonzero span")
	`CDD_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(dates_ok) && $stable(day_span), "stalled response changed")
	`CDD_ASSERT_IMP(a_no_phantom, clk, arst_n, rsp_valid, inflight_q != 3'd0, "response without a request")
	`CDD_ASSERT_IMP(a_depth, clk, arst_n, 1'b1, inflight_q <= 3'd4, "more beats held than stages")

endmodule

bind calendar_date_difference cdd_checker u_cdd_checker (.*);

/* verif/calendar_date_difference_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// calendar_date_difference_tb
// Self-checking bench for the Gregorian day-count block. A short table of
// date pairs (range extremes, saturation, malformed dates, leap corners) is
// driven first, then random pairs under four idle/stall mixes and a squeeze.
// Beats match in order: typed rows' own values, else an independent predictor.
// ----------------------------------------------------------------------------
module calendar_date_difference_tb;
	import cdd_pkg::*;

	localparam int YB           = YEAR_BITS_DEF;
	localparam int DIR_ROWS     = 24;
	localparam int PHASE_BEATS  = 200;
	localparam int SQUEEZE_BEATS = 40;
	localparam int HOLD_CYCLES  = 60;   // long response hold-off for the squeeze phase
	localparam int DRAIN_CYCLES = 12;   // pipeline is four deep, allow some slack
	localparam int IDLE_LIMIT   = 2000; // cycles with no handshake before giving up

	localparam logic [YB-1:0]          YEAR_TOP = '1;
	localparam logic [MONTH_W-1:0]     MON_NONE = 4'd0;
	localparam logic [MONTH_W-1:0]     MON_BAD  = 4'd13;
	localparam logic [MONTH_W-1:0]     MON_TOP  = 4'd15;
	localparam logic [DAY_W-1:0]       DAY_NONE = 5'd0;
	localparam logic [DAY_W-1:0]       DAY_ONE  = 5'd1;
	localparam logic signed [SPAN_W-1:0] SPAN_HI = {1'b0, {(SPAN_W-1){1'b1}}};
	localparam logic signed [SPAN_W-1:0] SPAN_LO = {1'b1, {(SPAN_W-1){1'b0}}};
	localparam longint SPAN_MAX_L = (longint'(1) << (SPAN_W-1)) - 1;
	localparam longint SPAN_MIN_L = -(longint'(1) << (SPAN_W-1));

	// one request beat; 'typed' rows carry their own expected response
	typedef struct packed {
		logic [DAY_W-1:0]          fd;
		logic [MONTH_W-1:0]        fm;
		logic [YB-1:0]             fy;
		logic [DAY_W-1:0]          ld;
		logic [MONTH_W-1:0]        lm;
		logic [YB-1:0]             ly;
		logic                      typed;
		logic                      ok;
		logic signed [SPAN_W-1:0]  span;
	} date_pair_t;

	typedef struct packed {
		logic                      ok;
		logic signed [SPAN_W-1:0]  span;
	} span_exp_t;

	logic                     clk;
	logic                     arst_n      = 1'b0;
	logic                     req_valid   = 1'b0;
	logic                     req_stall;
	logic [DAY_W-1:0]         first_day   = '0;
	logic [MONTH_W-1:0]       first_month = '0;
	logic [YB-1:0]            first_year  = '0;
	logic [DAY_W-1:0]         last_day    = '0;
	logic [MONTH_W-1:0]       last_month  = '0;
	logic [YB-1:0]            last_year   = '0;
	logic                     rsp_valid;
	logic                     rsp_stall   = 1'b0;
	logic                     dates_ok;
	logic signed [SPAN_W-1:0] day_span;

	span_exp_t  pending_spans[$];     // expected responses, oldest first
	date_pair_t dir_tab [DIR_ROWS];
	int         fault_count   = 0;
	int         send_idle_pct = 0;    // only the stimulus process touches this
	int         rsp_stall_pct = 0;    // written by NBA, read by the response side
	int         hold_asked    = 0;    // bumped by stimulus to request a hold-off
	int         hold_done     = 0;    // response side's count of holds started
	int         hold_left     = 0;
	int         quiet_cycles  = 0;

	calendar_date_difference uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.first_day  (first_day),
		.first_month(first_month),
		.first_year (first_year),
		.last_day   (last_day),
		.last_month (last_month),
		.last_year  (last_year),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.dates_ok   (dates_ok),
		.day_span   (day_span)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// Day-count predictor
	// ------------------------------------------------------------------------

	// Gregorian rule: every 400th year leap, otherwise every 4th bar centuries
	function automatic bit leap_year(input longint y);
		return (y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0));
	endfunction

	// length of month m in year y, 0 for a month code outside the calendar
	function automatic int month_len(input logic [MONTH_W-1:0] m, input longint y);
		if (m < MON_JAN || m > MON_DEC)
			return 0;
		case (m)
			MON_FEB:                            return leap_year(y) ? DAY_LEAP : DAY_LEAP - 1;
			MON_APR, MON_JUN, MON_SEP, MON_NOV: return DAY_SHORT;
			default:                            return DAY_LONG;
		endcase
	endfunction

	function automatic bit date_valid(input logic [DAY_W-1:0] d,
			input logic [MONTH_W-1:0] m, input logic [YB-1:0] y);
		int len;
		len = month_len(m, longint'(y));
		return (len != 0) && (d >= DAY_ONE) && (int'(d) <= len);
	endfunction

	// days since the eve of 1 January, year 0; earlier months summed from a
	// common year, plus one past February in a leap year
	function automatic longint day_number(input logic [DAY_W-1:0] d,
			input logic [MONTH_W-1:0] m, input logic [YB-1:0] y);
		longint yr;
		longint n;
		yr = longint'(y);
		n  = 365 * yr + (yr + 3) / 4 - (yr + 99) / 100 + (yr + 399) / 400 + longint'(d);
		for (int k = MON_JAN; k < m; k++)
			n += month_len(MONTH_W'(k), 1);
		if (m > MON_FEB && leap_year(yr))
			n++;
		return n;
	endfunction

	function automatic span_exp_t predict_span(input date_pair_t p);
		span_exp_t e;
		longint    diff;
		e.ok   = 1'b0;
		e.span = '0;
		if (date_valid(p.fd, p.fm, p.fy) && date_valid(p.ld, p.lm, p.ly)) begin
			diff = day_number(p.ld, p.lm, p.ly) - day_number(p.fd, p.fm, p.fy);
			if (diff > SPAN_MAX_L)
				diff = SPAN_MAX_L;
			if (diff < SPAN_MIN_L)
				diff = SPAN_MIN_L;
			e.ok   = 1'b1;
			e.span = diff[SPAN_W-1:0];
		end
		return e;
	endfunction

	// ------------------------------------------------------------------------
	// Random date pairs: mostly well-formed, years far apart, near or equal;
	// the rest raw noise across every field bit.
	// ------------------------------------------------------------------------
	function automatic date_pair_t random_pair();
		date_pair_t p;
		int         gap;
		p = '0;
		if ($urandom_range(99) < 15) begin
			p.fd = DAY_W'($urandom);
			p.fm = MONTH_W'($urandom);
			p.fy = YB'($urandom);
			p.ld = DAY_W'($urandom);
			p.lm = MONTH_W'($urandom);
			p.ly = YB'($urandom);
		end else begin
			p.fy = YB'($urandom);
			case ($urandom_range(2))
				0: begin
					p.ly = YB'($urandom);
				end
				1: begin
					gap  = int'($urandom_range(1600)) - 800;
					p.ly = YB'(int'(p.fy) + gap);   // wraps at the year width
				end
				default: begin
					p.ly = p.fy;
				end
			endcase
			p.fm = MONTH_W'($urandom_range(MON_DEC, MON_JAN));
			p.fd = DAY_W'($urandom_range(month_len(p.fm, longint'(p.fy)), DAY_ONE));
			p.lm = MONTH_W'($urandom_range(MON_DEC, MON_JAN));
			p.ld = DAY_W'($urandom_range(month_len(p.lm, longint'(p.ly)), DAY_ONE));
			// leap day on either side; rejected in common years
			if ($urandom_range(9) == 0) begin
				p.fm = MON_FEB;
				p.fd = DAY_LEAP;
			end
			if ($urandom_range(9) == 0) begin
				p.lm = MON_FEB;
				p.ld = DAY_LEAP;
			end
		end
		return p;
	endfunction

	// ------------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------------

	// offer one beat, hold it until taken, then log what should come back;
	// valid is left high, so back-to-back beats keep req_valid asserted
	task automatic offer_dates(input date_pair_t p);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid   <= 1'b1;
		first_day   <= p.fd;
		first_month <= p.fm;
		first_year  <= p.fy;
		last_day    <= p.ld;
		last_month  <= p.lm;
		last_year   <= p.ly;
		do
			@(posedge clk);
		while (req_stall);
		if (p.typed)
			pending_spans.push_back('{ok: p.ok, span: p.span});
		else
			pending_spans.push_back(predict_span(p));
	endtask

	// drop valid and wait for every outstanding response
	task automatic drain_pending();
		req_valid <= 1'b0;
		while (pending_spans.size() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Response side: checker plus stall generator. A hold-off request from the
	// stimulus is counted out here, cycle by cycle.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		span_exp_t e;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_spans.size() == 0) begin
				$error("response beat with nothing outstanding: dates_ok %0b day_span %0d",
					dates_ok, day_span);
				fault_count++;
			end else begin
				e = pending_spans.pop_front();
				if (dates_ok !== e.ok) begin
					$error("dates_ok: expected %0b, got %0b", e.ok, dates_ok);
					fault_count++;
				end
				if (day_span !== e.span) begin
					$error("day_span: expected %0d, got %0d", e.span, day_span);
					fault_count++;
				end
			end
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else if (hold_done != hold_asked) begin
			hold_done++;
			hold_left = HOLD_CYCLES - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
		end
	end

	// watchdog: too long without a beat on either channel means a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("calendar_date_difference_tb: done, errors");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin
		// fd, fm, fy, ld, lm, ly, typed, ok, span
		dir_tab = '{
			// all fields zero / all fields one: both malformed
			'{DAY_NONE, MON_NONE, '0,       DAY_NONE, MON_NONE, '0,       1'b1, 1'b0, '0},
			'{DAY_LONG, MON_TOP,  YEAR_TOP, DAY_LONG, MON_TOP,  YEAR_TOP, 1'b1, 1'b0, '0},
			// identical dates at both ends of the year range
			'{DAY_ONE,  MON_JAN,  '0,       DAY_ONE,  MON_JAN,  '0,       1'b1, 1'b1, '0},
			'{DAY_LONG, MON_DEC,  YEAR_TOP, DAY_LONG, MON_DEC,  YEAR_TOP, 1'b1, 1'b1, '0},
			// widest spans clip at the positive and negative limits
			'{DAY_ONE,  MON_JAN,  '0,       DAY_LONG, MON_DEC,  YEAR_TOP, 1'b1, 1'b1, SPAN_HI},
			'{DAY_LONG, MON_DEC,  YEAR_TOP, DAY_ONE,  MON_JAN,  '0,       1'b1, 1'b1, SPAN_LO},
			// month and day codes off the calendar
			'{DAY_ONE,  MON_BAD,  14'd2000, DAY_ONE,  MON_JAN,  14'd2000, 1'b1, 1'b0, '0},
			'{DAY_ONE,  MON_JAN,  14'd2000, DAY_NONE, MON_MAR,  14'd2000, 1'b1, 1'b0, '0},
			// 31st of a thirty-day month, on either side
			'{DAY_LONG, MON_APR,  14'd2021, DAY_ONE,  MON_JAN,  14'd2021, 1'b1, 1'b0, '0},
			'{DAY_ONE,  MON_JAN,  14'd2021, DAY_LONG, MON_JUN,  14'd2021, 1'b1, 1'b0, '0},
			'{DAY_LONG, MON_SEP,  14'd1999, DAY_ONE,  MON_JUL,  14'd1999, 1'b1, 1'b0, '0},
			'{DAY_ONE,  MON_MAY,  14'd1999, DAY_LONG, MON_NOV,  14'd1999, 1'b1, 1'b0, '0},
			// February past its end; leap day in common years incl. a century
			'{DAY_SHORT, MON_FEB, 14'd2024, DAY_ONE,  MON_JAN,  14'd2024, 1'b1, 1'b0, '0},
			'{DAY_ONE,  MON_JAN,  14'd2024, DAY_LONG, MON_FEB,  14'd2024, 1'b1, 1'b0, '0},
			'{DAY_LEAP, MON_FEB,  14'd1900, DAY_ONE,  MON_MAR,  14'd1900, 1'b1, 1'b0, '0},
			'{DAY_ONE,  MON_MAR,  14'd2023, DAY_LEAP, MON_FEB,  14'd2023, 1'b1, 1'b0, '0},
			// leap days that do exist: 400-year rule, year 0, far year
			'{DAY_LEAP, MON_FEB,  14'd2000, DAY_ONE,  MON_MAR,  14'd2000, 1'b0, 1'b0, '0},
			'{DAY_LEAP, MON_FEB,  '0,       DAY_ONE,  MON_JAN,  14'd1,    1'b0, 1'b0, '0},
			'{DAY_ONE,  MON_JAN,  YEAR_TOP, DAY_LEAP, MON_FEB,  14'd16000, 1'b0, 1'b0, '0},
			// same leap year across the end of February
			'{DAY_ONE,  MON_JAN,  14'd2024, DAY_ONE,  MON_MAR,  14'd2024, 1'b0, 1'b0, '0},
			// start after end gives a negative count; end of February in 2100
			'{5'd15,    MON_AUG,  14'd2030, 5'd3,     MON_MAY,  14'd1987, 1'b0, 1'b0, '0},
			'{5'd28,    MON_FEB,  14'd2100, DAY_ONE,  MON_MAR,  14'd2100, 1'b0, 1'b0, '0},
			// crossing into year 10000, and a span across the 400-year leap year 1600
			'{DAY_LONG, MON_DEC,  14'd9999, DAY_ONE,  MON_JAN,  14'd10000, 1'b0, 1'b0, '0},
			'{DAY_SHORT, MON_JUN, 14'd1600, DAY_LONG, MON_JUL,  14'd1601, 1'b0, 1'b0, '0}
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table at full rate
		foreach (dir_tab[i])
			offer_dates(dir_tab[i]);
		drain_pending();

		// random pairs under each idle/stall mix
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  rsp_stall_pct <= 0;  end
				1: begin send_idle_pct = 64; rsp_stall_pct <= 0;  end
				2: begin send_idle_pct = 0;  rsp_stall_pct <= 64; end
				default: begin send_idle_pct = 33; rsp_stall_pct <= 33; end
			endcase
			repeat (PHASE_BEATS)
				offer_dates(random_pair());
		end

		// squeeze: long hold on the response side while requests keep coming,
		// so the pipeline fills and backs up into req_stall
		send_idle_pct = 0;
		rsp_stall_pct <= 0;
		hold_asked    <= hold_asked + 1;
		repeat (SQUEEZE_BEATS)
			offer_dates(random_pair());

		drain_pending();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fault_count == 0)
			$display("calendar_date_difference_tb: done, clean");
		else
			$display("calendar_date_difference_tb: done, errors");
		$finish;
	end

endmodule

/* calendar_date_difference.f */
+incdir+src
src/cdd_pkg.sv
src/cdd_ordinal.sv
src/calendar_date_difference.sv
src/cdd_checker.sv
verif/calendar_date_difference_tb.sv
